@@ rtl/core/ptd_pkg.sv @@
package ptd_pkg;

  localparam int NUM_QUEUES          = 4;
  localparam int QW                  = $clog2(NUM_QUEUES);
  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int ID_W                = 16;
  localparam int TOTAL_W             = 7;
  localparam int TOTAL_MAX           = (1 << TOTAL_W) - 1;

  // Queue indices in priority order.
  localparam logic [QW-1:0] Q_HI_MAIN = 2'd0;
  localparam logic [QW-1:0] Q_LO_MAIN = 2'd1;
  localparam logic [QW-1:0] Q_HI_GEN  = 2'd2;
  localparam logic [QW-1:0] Q_LO_GEN  = 2'd3;

  typedef enum logic [1:0] {
    OP_SUBMIT  = 2'd0,
    OP_REQUEST = 2'd1,
    OP_CLEAR   = 2'd2
  } ptd_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } ptd_status_t;

  // Result fields known at acceptance; the granted id follows from the memory.
  typedef struct packed {
    logic               granted;
    ptd_status_t        status;
    logic [TOTAL_W-1:0] total;
  } ptd_meta_t;

endpackage

@@ rtl/core/ptd_queue_mem.sv @@
module ptd_queue_mem import ptd_pkg::*; #(
  parameter int AW = QW + $clog2(DEFAULT_QUEUE_DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [ID_W-1:0] wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [ID_W-1:0] rd_data
);

  logic [ID_W-1:0] mem [0:(1 << AW)-1];
  logic [ID_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/ptd_ctrl.sv @@
module ptd_ctrl import ptd_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int PW = $clog2(QUEUE_DEPTH),
  localparam int AW = QW + PW
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [1:0]      op,
  input  logic [ID_W-1:0] task_id,
  input  logic            needs_main,
  input  logic            high_prio,
  input  logic            worker_main,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [ID_W-1:0] wr_data,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  output ptd_meta_t       meta
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (CW + 2 > TOTAL_W) ? CW + 2 : TOTAL_W;

  logic [PW-1:0] head_r [NUM_QUEUES];
  logic [PW-1:0] head_nxt [NUM_QUEUES];
  logic [PW-1:0] tail_r [NUM_QUEUES];
  logic [PW-1:0] tail_nxt [NUM_QUEUES];
  logic [CW-1:0] cnt_r [NUM_QUEUES];
  logic [CW-1:0] cnt_nxt [NUM_QUEUES];

  logic [QW-1:0] push_q;
  logic [QW-1:0] pop_q;
  logic          pop_found;
  logic          push_ok;
  logic          pop_ok;
  logic [SW-1:0] sum;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Submit target: main need picks the lower pair, low priority the odd queue.
  assign push_q = {~needs_main, ~high_prio};

  always_comb begin
    pop_q     = Q_HI_GEN;
    pop_found = 1'b1;
    priority if (worker_main && cnt_r[Q_HI_MAIN] != '0) begin
      pop_q = Q_HI_MAIN;
    end else if (worker_main && cnt_r[Q_LO_MAIN] != '0) begin
      pop_q = Q_LO_MAIN;
    end else if (cnt_r[Q_HI_GEN] != '0) begin
      pop_q = Q_HI_GEN;
    end else if (cnt_r[Q_LO_GEN] != '0) begin
      pop_q = Q_LO_GEN;
    end else begin
      pop_found = 1'b0;
    end
  end

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    push_ok      = 1'b0;
    pop_ok       = 1'b0;
    meta.granted = 1'b0;
    meta.status  = ST_OK;
    unique case (ptd_op_t'(op))
      OP_SUBMIT: begin
        if (cnt_r[push_q] == CW'(QUEUE_DEPTH)) begin
          meta.status = ST_FULL;
        end else begin
          push_ok          = 1'b1;
          tail_nxt[push_q] = next_ptr(tail_r[push_q]);
          cnt_nxt[push_q]  = cnt_r[push_q] + 1'b1;
        end
      end
      OP_REQUEST: begin
        if (pop_found) begin
          pop_ok          = 1'b1;
          meta.granted    = 1'b1;
          head_nxt[pop_q] = next_ptr(head_r[pop_q]);
          cnt_nxt[pop_q]  = cnt_r[pop_q] - 1'b1;
        end else begin
          meta.status = ST_EMPTY;
        end
      end
      OP_CLEAR: begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
          head_nxt[q] = '0;
          tail_nxt[q] = '0;
          cnt_nxt[q]  = '0;
        end
      end
      default: begin
      end
    endcase
    sum = SW'(cnt_nxt[0]) + SW'(cnt_nxt[1]) + SW'(cnt_nxt[2]) + SW'(cnt_nxt[3]);
    meta.total = (sum > SW'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX) : sum[TOTAL_W-1:0];
  end

  assign wr_en   = acc && push_ok;
  assign wr_addr = {push_q, tail_r[push_q]};
  assign wr_data = task_id;
  assign rd_en   = acc && pop_ok;
  assign rd_addr = {pop_q, head_r[pop_q]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        cnt_r[q]  <= '0;
      end
    end else if (acc) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/priority_task_dispatcher_top.sv @@
// A word's result passes through the stage-1 registers and then the output registers.
// Throughput: one word per cycle; the only wait is a stall on the result side.
// The registered queue memory read sets the latency; pointers and counts
// update in the cycle of acceptance, so back-to-back words see current state.
// Reset (synchronous, rst_n low) empties all queues; stored ids are not cleared.
module priority_task_dispatcher_top import ptd_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_op,
  input  logic [ID_W-1:0] in_task_id,
  input  logic            in_needs_main,
  input  logic            in_high_prio,
  input  logic            in_worker_main,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_granted,
  output logic [ID_W-1:0] out_granted_id,
  output logic [1:0]      out_status,
  output logic [TOTAL_W-1:0] out_queued_total
);

  localparam int AW = QW + $clog2(QUEUE_DEPTH);

  logic            acc;
  logic            out_free;
  logic            s1_adv;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [ID_W-1:0] wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [ID_W-1:0] rd_data;
  ptd_meta_t       meta;

  logic            s1_valid_r;
  ptd_meta_t       s1_meta_r;
  logic            out_valid_r;
  logic            out_granted_r;
  logic [ID_W-1:0] out_granted_id_r;
  logic [1:0]      out_status_r;
  logic [TOTAL_W-1:0] out_total_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign acc      = in_valid && !in_stall;

  ptd_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .op          (in_op),
    .task_id     (in_task_id),
    .needs_main  (in_needs_main),
    .high_prio   (in_high_prio),
    .worker_main (in_worker_main),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .meta        (meta)
  );

  ptd_queue_mem #(
    .AW(AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_meta_r <= meta;
    end
    // The memory read data is held until this stage moves on.
    if (s1_adv) begin
      out_granted_r    <= s1_meta_r.granted;
      out_granted_id_r <= s1_meta_r.granted ? rd_data : '0;
      out_status_r     <= s1_meta_r.status;
      out_total_r      <= s1_meta_r.total;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_granted_id   = out_granted_id_r;
  assign out_status       = out_status_r;
  assign out_queued_total = out_total_r;

endmodule
